FILE: src/pclic_pkg.sv
// ---------------------------------------------------------------------------
// pclic_pkg
// Types and register map constants for the per-CPU local interrupt
// controller.
// ---------------------------------------------------------------------------
package pclic_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_READ   = 2'd1,
		MODE_UPDATE = 2'd2
	} mode_t;

	// register word indexes (byte offset / 4)
	localparam logic [5:0] W_CONTROL   = 6'd0;
	localparam logic [5:0] W_PRESCALER = 6'd2;
	localparam logic [5:0] W_GPU_ROUTE = 6'd3;
	localparam logic [5:0] W_PMU_SET   = 6'd4;
	localparam logic [5:0] W_PMU_CLR   = 6'd5;

	// word_index[5:4] for the per-CPU block at 0x040..0x07c
	localparam logic [1:0] REGION_CPU = 2'b01;
	// word_index[3:2] inside the per-CPU block
	localparam logic [1:0] SUB_TEN  = 2'd0;
	localparam logic [1:0] SUB_MEN  = 2'd1;
	localparam logic [1:0] SUB_IRQP = 2'd2;
	localparam logic [1:0] SUB_FIQP = 2'd3;

	typedef logic [9:0] pend_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  word_index;
		logic [31:0] write_data;
		logic [15:0] timer_lines;
		logic        gpu_line;
		logic [3:0]  pmu_lines;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [3:0]  irq_out;
		logic [3:0]  fiq_out;
	} rsp_t;

	// interrupt sources seen by the pending logic
	typedef struct packed {
		logic [15:0] timer_lv;
		logic        gpu_lv;
		logic [1:0]  gpu_cpu;
		logic [3:0]  pmu;      // levels already masked by enables
	} src_t;

endpackage

FILE: src/pclic_req_if.sv
// ---------------------------------------------------------------------------
// pclic_req_if
// Request channel: register access or source line update.
// ---------------------------------------------------------------------------
interface pclic_req_if import pclic_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/pclic_rsp_if.sv
// ---------------------------------------------------------------------------
// pclic_rsp_if
// Response channel: read data and per-CPU IRQ/FIQ lines.
// ---------------------------------------------------------------------------
interface pclic_rsp_if import pclic_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/pclic_ram.sv
// ---------------------------------------------------------------------------
// pclic_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pclic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/pclic_pend.sv
// ---------------------------------------------------------------------------
// pclic_pend
// Per-CPU IRQ and FIQ pending words from source levels and enables.
// ---------------------------------------------------------------------------
module pclic_pend import pclic_pkg::*; #(
	parameter int NUM_CPUS          = 4,
	parameter int MAILBOXES_PER_CPU = 4
) (
	input  src_t                        src,
	input  logic [NUM_CPUS-1:0][7:0]    ten,
	input  logic [NUM_CPUS-1:0][7:0]    men,
	input  logic [NUM_CPUS*4-1:0]       mb_nz,
	output pend_t [NUM_CPUS-1:0]        irq_pend,
	output pend_t [NUM_CPUS-1:0]        fiq_pend
);

	for (genvar c = 0; c < NUM_CPUS; c++) begin : g_cpu
		pend_t irq_w;
		pend_t fiq_w;

		always_comb begin
			irq_w = '0;
			fiq_w = '0;
			for (int k = 0; k < 4; k++) begin
				// FIQ enable overrides IRQ enable
				if (src.timer_lv[c*4+k]) begin
					if (ten[c][4+k]) begin
						fiq_w[k] = 1'b1;
					end else if (ten[c][k]) begin
						irq_w[k] = 1'b1;
					end
				end
				if (k < MAILBOXES_PER_CPU && mb_nz[c*4+k]) begin
					if (men[c][4+k]) begin
						fiq_w[4+k] = 1'b1;
					end else if (men[c][k]) begin
						irq_w[4+k] = 1'b1;
					end
				end
			end
			irq_w[8] = src.gpu_lv && (src.gpu_cpu == 2'(c));
			irq_w[9] = src.pmu[c];
		end

		assign irq_pend[c] = irq_w;
		assign fiq_pend[c] = fiq_w;
	end

endmodule

FILE: src/per_cpu_local_interrupt_controller_unit.sv
// ---------------------------------------------------------------------------
// per_cpu_local_interrupt_controller_unit
// Local interrupt controller for up to four CPUs: register file, mailboxes
// and IRQ/FIQ pending logic.
// ---------------------------------------------------------------------------
// One transaction per clock when the response side does not stall: each
// request gives one response, registered after stage 1. Mailbox words sit in
// a RAM with a registered read; the RAM is read as the request is taken and
// the set/clear result is written back as the request leaves stage 1, so the
// read-modify-write loop runs through that RAM port. A request that touches the
// mailbox written in the same cycle gets the new word forwarded. Per-entry
// valid bits make the RAM read as zero after reset, so no clearing pass is
// needed. irq_out and fiq_out show the state after the request has acted.
// ---------------------------------------------------------------------------
module per_cpu_local_interrupt_controller_unit import pclic_pkg::*; #(
	parameter int NUM_CPUS          = 4,
	parameter int MAILBOXES_PER_CPU = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	pclic_req_if.sink  req,
	pclic_rsp_if.source rsp
);

	localparam int SLOTS = NUM_CPUS * 4;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
	localparam logic [3:0] CPU_MASK = 4'((1 << NUM_CPUS) - 1);

	// pipeline
	logic        v_s1;
	req_t        req_s1;
	logic        hit_s1;
	logic        out_v_q;
	rsp_t        rsp_q;
	logic        adv;
	logic        in_ready;
	logic        in_take;

	// state
	logic [31:0]              ctrl_q, ctrl_d;
	logic [31:0]              presc_q, presc_d;
	logic [3:0]               route_q, route_d;
	logic [3:0]               pmu_en_q, pmu_en_d;
	logic [NUM_CPUS-1:0][7:0] ten_q, ten_d;
	logic [NUM_CPUS-1:0][7:0] men_q, men_d;
	logic [SLOTS-1:0]         nz_q, nz_d;
	logic [SLOTS-1:0]         vld_q, vld_d;
	logic [15:0]              tlv_q, tlv_d;
	logic                     gpu_q, gpu_d;
	logic [3:0]               pmu_lv_q, pmu_lv_d;
	logic [31:0]              fwd_q;

	// stage 1 decode
	logic [5:0]    w;
	logic [31:0]   d;
	mode_t         mode;
	logic [CW-1:0] cpu_idx;
	logic          cpu_ok;
	logic          mb_ok;
	logic [AW-1:0] mb_addr;
	logic [AW-1:0] in_addr;
	logic [31:0]   ram_rdata;
	logic [31:0]   mb_cur;
	logic [31:0]   mb_new;
	logic          mb_we;
	logic [31:0]   rd;

	src_t                   src_cur, src_nxt;
	pend_t [NUM_CPUS-1:0]   irq_cur, fiq_cur, irq_nxt, fiq_nxt;
	logic [NUM_CPUS-1:0]    irq_lines, fiq_lines;

	assign adv      = !out_v_q || rsp.ready;
	assign in_ready = !v_s1 || adv;
	assign in_take  = req.valid && in_ready;
	assign req.ready = in_ready;

	assign w       = req_s1.word_index;
	assign d       = req_s1.write_data;
	assign mode    = mode_t'(req_s1.mode);
	assign cpu_idx = w[CW-1:0];
	assign cpu_ok  = {1'b0, w[1:0]} < 3'(NUM_CPUS);
	assign mb_ok   = w[5] && ({1'b0, w[3:2]} < 3'(NUM_CPUS))
		&& ({1'b0, w[1:0]} < 3'(MAILBOXES_PER_CPU));
	assign mb_addr = w[AW-1:0];
	assign in_addr = req.payload.word_index[AW-1:0];

	pclic_ram #(
		.WIDTH (32),
		.DEPTH (SLOTS)
	) u_mbx_ram (
		.clk   (clk),
		.we    (mb_we),
		.waddr (mb_addr),
		.wdata (mb_new),
		.re    (in_take),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (hit_s1) begin
			mb_cur = fwd_q;
		end else if (vld_q[mb_addr]) begin
			mb_cur = ram_rdata;
		end else begin
			mb_cur = '0;
		end
	end

	// upper half of the mailbox window clears, lower half sets
	assign mb_new = w[4] ? (mb_cur & ~d) : (mb_cur | d);

	// next state
	always_comb begin
		ctrl_d   = ctrl_q;
		presc_d  = presc_q;
		route_d  = route_q;
		pmu_en_d = pmu_en_q;
		ten_d    = ten_q;
		men_d    = men_q;
		nz_d     = nz_q;
		vld_d    = vld_q;
		tlv_d    = tlv_q;
		gpu_d    = gpu_q;
		pmu_lv_d = pmu_lv_q;
		mb_we    = 1'b0;
		if (v_s1 && adv) begin
			unique case (mode)
				MODE_WRITE: begin
					unique case (w)
						W_CONTROL:   ctrl_d = d;
						W_PRESCALER: presc_d = d;
						W_GPU_ROUTE: route_d = d[3:0];
						W_PMU_SET:   pmu_en_d = pmu_en_q | d[3:0];
						W_PMU_CLR:   pmu_en_d = pmu_en_q & ~d[3:0];
						default: begin
							if (w[5:4] == REGION_CPU && cpu_ok) begin
								if (w[3:2] == SUB_TEN) begin
									ten_d[cpu_idx] = d[7:0];
								end else if (w[3:2] == SUB_MEN) begin
									men_d[cpu_idx] = d[7:0];
								end
							end
							if (mb_ok) begin
								mb_we          = 1'b1;
								nz_d[mb_addr]  = (mb_new != '0);
								vld_d[mb_addr] = 1'b1;
							end
						end
					endcase
				end
				MODE_UPDATE: begin
					tlv_d    = req_s1.timer_lines;
					gpu_d    = req_s1.gpu_line;
					pmu_lv_d = req_s1.pmu_lines;
				end
				default: ;
			endcase
		end
	end

	assign src_cur = '{timer_lv: tlv_q, gpu_lv: gpu_q, gpu_cpu: route_q[1:0],
		pmu: pmu_lv_q & pmu_en_q};
	assign src_nxt = '{timer_lv: tlv_d, gpu_lv: gpu_d, gpu_cpu: route_d[1:0],
		pmu: pmu_lv_d & pmu_en_d};

	pclic_pend #(
		.NUM_CPUS          (NUM_CPUS),
		.MAILBOXES_PER_CPU (MAILBOXES_PER_CPU)
	) u_pend_cur (
		.src      (src_cur),
		.ten      (ten_q),
		.men      (men_q),
		.mb_nz    (nz_q),
		.irq_pend (irq_cur),
		.fiq_pend (fiq_cur)
	);

	pclic_pend #(
		.NUM_CPUS          (NUM_CPUS),
		.MAILBOXES_PER_CPU (MAILBOXES_PER_CPU)
	) u_pend_nxt (
		.src      (src_nxt),
		.ten      (ten_d),
		.men      (men_d),
		.mb_nz    (nz_d),
		.irq_pend (irq_nxt),
		.fiq_pend (fiq_nxt)
	);

	for (genvar c = 0; c < NUM_CPUS; c++) begin : g_lines
		assign irq_lines[c] = |irq_nxt[c];
		assign fiq_lines[c] = |fiq_nxt[c];
	end

	// read data
	always_comb begin
		rd = '0;
		if (mode == MODE_READ) begin
			unique case (w)
				W_CONTROL:   rd = ctrl_q;
				W_PRESCALER: rd = presc_q;
				W_GPU_ROUTE: rd = {28'b0, route_q};
				W_PMU_SET,
				W_PMU_CLR:   rd = {28'b0, pmu_en_q};
				default: begin
					if (w[5:4] == REGION_CPU && cpu_ok) begin
						unique case (w[3:2])
							SUB_TEN:  rd = {24'b0, ten_q[cpu_idx]};
							SUB_MEN:  rd = {24'b0, men_q[cpu_idx]};
							SUB_IRQP: rd = {22'b0, irq_cur[cpu_idx]};
							SUB_FIQP: rd = {22'b0, fiq_cur[cpu_idx]};
							default:  rd = '0;
						endcase
					end else if (mb_ok) begin
						rd = mb_cur;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
			ctrl_q   <= '0;
			presc_q  <= '0;
			route_q  <= '0;
			pmu_en_q <= '0;
			ten_q    <= '0;
			men_q    <= '0;
			nz_q     <= '0;
			vld_q    <= '0;
			tlv_q    <= '0;
			gpu_q    <= 1'b0;
			pmu_lv_q <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
			ctrl_q   <= ctrl_d;
			presc_q  <= presc_d;
			route_q  <= route_d;
			pmu_en_q <= pmu_en_d;
			ten_q    <= ten_d;
			men_q    <= men_d;
			nz_q     <= nz_d;
			vld_q    <= vld_d;
			tlv_q    <= tlv_d;
			gpu_q    <= gpu_d;
			pmu_lv_q <= pmu_lv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= req.payload;
			// entry being written back this edge is read this edge too
			hit_s1 <= mb_we && req.payload.word_index[5] && (in_addr == mb_addr);
		end
		if (mb_we) begin
			fwd_q <= mb_new;
		end
		if (v_s1 && adv) begin
			rsp_q.read_data <= rd;
			rsp_q.irq_out   <= 4'(irq_lines);
			rsp_q.fiq_out   <= 4'(fiq_lines);
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.payload = rsp_q;

	// forwarding only ever applies to a mailbox access
	a_hit_mailbox: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && hit_s1 |-> req_s1.word_index[5])
		else $error("forward hit on a non-mailbox access");

	// absent CPUs never raise a line
	a_absent_cpu: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.payload.irq_out | rsp.payload.fiq_out) & ~CPU_MASK) == 4'b0)
		else $error("interrupt line raised for an absent CPU");

	// nonzero flag tracks the word written back to the mailbox RAM
	a_nz_track: assert property (@(posedge clk) disable iff (!arst_n)
		mb_we |=> vld_q[$past(mb_addr)] && (nz_q[$past(mb_addr)] == ($past(mb_new) != '0)))
		else $error("mailbox nonzero flag out of step with write-back");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the per-CPU local interrupt controller. Drives register
// writes, reads and source line updates with random gaps on the request side
// and random stalls on the response side. A scoreboard keeps its own copy of
// the register file and pending logic and checks every response in order.
// ---------------------------------------------------------------------------
module tb_top import pclic_pkg::*; ();

	localparam int NUM_CPUS      = 4;
	localparam int MBOX_PER_CPU  = 4;
	localparam int RANDOM_ITEMS  = 400;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int REPORT_LIMIT  = 10;

	// word indexes of the per-CPU blocks and the mailbox windows
	localparam logic [5:0] W_TEN_BASE      = {REGION_CPU, SUB_TEN, 2'd0};
	localparam logic [5:0] W_MEN_BASE      = {REGION_CPU, SUB_MEN, 2'd0};
	localparam logic [5:0] W_IRQP_BASE     = {REGION_CPU, SUB_IRQP, 2'd0};
	localparam logic [5:0] W_FIQP_BASE     = {REGION_CPU, SUB_FIQP, 2'd0};
	localparam logic [5:0] W_MBOX_SET_BASE = 6'd32;
	localparam logic [5:0] W_MBOX_CLR_BASE = 6'd48;
	localparam logic [5:0] W_UNMAPPED_LO   = 6'd1;
	localparam logic [5:0] W_UNMAPPED_HI   = 6'd15;
	localparam logic [1:0] MODE_RESERVED   = 2'd3;

	class pclic_scoreboard;
		bit [31:0] control_reg;
		bit [31:0] prescale_reg;
		bit [3:0]  gpu_route;
		bit [3:0]  pmu_en;
		bit [7:0]  timer_en [4];
		bit [7:0]  mbox_en [4];
		bit [31:0] mbox [16];
		bit [15:0] timer_lv;
		bit        gpu_lv;
		bit [3:0]  pmu_lv;
		rsp_t      expected_rsp_q [$];
		int        errors;

		function pend_t pending_word(int unsigned cpu, bit want_fiq);
			pend_t irq_w;
			pend_t fiq_w;
			irq_w = '0;
			fiq_w = '0;
			if (cpu >= NUM_CPUS)
				return '0;
			for (int k = 0; k < 4; k++) begin
				// FIQ enable wins over IRQ enable
				if (timer_lv[cpu*4+k]) begin
					if (timer_en[cpu][4+k])
						fiq_w[k] = 1'b1;
					else if (timer_en[cpu][k])
						irq_w[k] = 1'b1;
				end
				if (k < MBOX_PER_CPU && mbox[cpu*4+k] != 0) begin
					if (mbox_en[cpu][4+k])
						fiq_w[4+k] = 1'b1;
					else if (mbox_en[cpu][k])
						irq_w[4+k] = 1'b1;
				end
			end
			if (gpu_lv && gpu_route[1:0] == cpu)
				irq_w[8] = 1'b1;
			if (pmu_lv[cpu] && pmu_en[cpu])
				irq_w[9] = 1'b1;
			return want_fiq ? fiq_w : irq_w;
		endfunction

		function bit mbox_slot(int unsigned w, output int unsigned slot);
			int unsigned rel;
			rel = (w - W_MBOX_SET_BASE) & 15;
			slot = rel;
			return (rel >> 2) < NUM_CPUS && (rel & 3) < MBOX_PER_CPU;
		endfunction

		function bit [31:0] read_word(int unsigned w);
			int unsigned slot;
			int unsigned cpu;
			cpu = w & 3;
			if (w == W_CONTROL) return control_reg;
			if (w == W_PRESCALER) return prescale_reg;
			if (w == W_GPU_ROUTE) return 32'(gpu_route);
			if (w == W_PMU_SET || w == W_PMU_CLR) return 32'(pmu_en);
			if (w >= W_TEN_BASE && w < W_MBOX_SET_BASE) begin
				if (cpu >= NUM_CPUS) return '0;
				if (w < W_MEN_BASE) return 32'(timer_en[cpu]);
				if (w < W_IRQP_BASE) return 32'(mbox_en[cpu]);
				return 32'(pending_word(cpu, w >= W_FIQP_BASE));
			end
			if (w >= W_MBOX_SET_BASE && mbox_slot(w, slot))
				return mbox[slot];
			return '0;
		endfunction

		function void write_word(int unsigned w, bit [31:0] d);
			int unsigned slot;
			int unsigned cpu;
			cpu = w & 3;
			if (w == W_CONTROL) control_reg = d;
			else if (w == W_PRESCALER) prescale_reg = d;
			else if (w == W_GPU_ROUTE) gpu_route = d[3:0];
			else if (w == W_PMU_SET) pmu_en |= d[3:0];
			else if (w == W_PMU_CLR) pmu_en &= ~d[3:0];
			else if (w >= W_TEN_BASE && w < W_IRQP_BASE) begin
				if (cpu < NUM_CPUS) begin
					if (w < W_MEN_BASE)
						timer_en[cpu] = d[7:0];
					else
						mbox_en[cpu] = d[7:0];
				end
			end else if (w >= W_MBOX_SET_BASE && mbox_slot(w, slot)) begin
				if (w < W_MBOX_CLR_BASE)
					mbox[slot] |= d;
				else
					mbox[slot] &= ~d;
			end
		endfunction

		function void take_request(req_t r);
			rsp_t exp;
			exp = '0;
			case (r.mode)
				MODE_WRITE: write_word(r.word_index, r.write_data);
				MODE_READ: exp.read_data = read_word(r.word_index);
				MODE_UPDATE: begin
					timer_lv = r.timer_lines;
					gpu_lv   = r.gpu_line;
					pmu_lv   = r.pmu_lines;
				end
				default: ;
			endcase
			for (int c = 0; c < NUM_CPUS; c++) begin
				exp.irq_out[c] = pending_word(c, 1'b0) != 0;
				exp.fiq_out[c] = pending_word(c, 1'b1) != 0;
			end
			expected_rsp_q.push_back(exp);
		endfunction

		function void check_response(rsp_t got);
			rsp_t exp;
			if (expected_rsp_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected response: read_data %h irq %b fiq %b",
						got.read_data, got.irq_out, got.fiq_out);
				return;
			end
			exp = expected_rsp_q.pop_front();
			if (got.read_data !== exp.read_data || got.irq_out !== exp.irq_out ||
					got.fiq_out !== exp.fiq_out) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("mismatch: read_data exp %h got %h, irq exp %b got %b, fiq exp %b got %b",
						exp.read_data, got.read_data, exp.irq_out, got.irq_out,
						exp.fiq_out, got.fiq_out);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   req_fire;
	bit   rsp_fire;
	bit   full_rate;
	int   cycle_count;
	pclic_scoreboard sb;

	pclic_req_if req_if ();
	pclic_rsp_if rsp_if ();

	per_cpu_local_interrupt_controller_unit #(
		.NUM_CPUS         (NUM_CPUS),
		.MAILBOXES_PER_CPU(MBOX_PER_CPU)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// transaction monitor: request noted before the response is checked
	always @(posedge clk) begin
		req_fire = req_if.valid && req_if.ready;
		rsp_fire = rsp_if.valid && rsp_if.ready;
		if (req_fire)
			sb.take_request(req_if.payload);
		if (rsp_fire)
			sb.check_response(rsp_if.payload);
	end

	// response side: random stall before taking each transaction
	initial begin
		int gap;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = full_rate ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(negedge clk); while (!rsp_fire);
		end
	end

	function automatic req_t make_req(logic [1:0] m, logic [5:0] w, logic [31:0] d);
		req_t r;
		r.mode        = m;
		r.word_index  = w;
		r.write_data  = d;
		r.timer_lines = 16'($urandom);
		r.gpu_line    = 1'($urandom_range(0, 1));
		r.pmu_lines   = 4'($urandom_range(0, 15));
		return r;
	endfunction

	function automatic req_t make_update(logic [15:0] tl, logic gl, logic [3:0] pl);
		req_t r;
		r = make_req(MODE_UPDATE, 6'($urandom_range(0, 63)), $urandom);
		r.timer_lines = tl;
		r.gpu_line    = gl;
		r.pmu_lines   = pl;
		return r;
	endfunction

	// entered and left at a falling edge; valid stays high across back-to-back items
	task automatic send_request(req_t r);
		int gap;
		gap = full_rate ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do @(negedge clk); while (!req_fire);
	endtask

	initial begin
		req_t        r;
		int          sel;
		logic [1:0]  m;
		logic [5:0]  w;
		logic [31:0] d;

		sb = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		send_request(make_req(MODE_READ, W_CONTROL, $urandom));
		send_request(make_req(MODE_WRITE, W_CONTROL, 32'hFFFF_FFFF));
		send_request(make_req(MODE_READ, W_CONTROL, $urandom));
		send_request(make_req(MODE_WRITE, W_PRESCALER, 32'hA5A5_5A5A));
		send_request(make_req(MODE_READ, W_PRESCALER, $urandom));
		send_request(make_req(MODE_WRITE, W_GPU_ROUTE, 32'hFFFF_FFFF));
		send_request(make_req(MODE_READ, W_GPU_ROUTE, $urandom));
		send_request(make_update(16'hFFFF, 1'b1, 4'hF));
		send_request(make_req(MODE_WRITE, W_PMU_SET, 32'hFFFF_FFF5));
		send_request(make_req(MODE_WRITE, W_PMU_CLR, 32'h0000_0001));
		send_request(make_req(MODE_READ, W_PMU_CLR, $urandom));
		send_request(make_req(MODE_WRITE, W_TEN_BASE, 32'hFFFF_FFFF));
		send_request(make_req(MODE_WRITE, W_TEN_BASE + 6'd1, 32'h0000_000F));
		send_request(make_req(MODE_WRITE, W_MBOX_SET_BASE + 6'd11, 32'h8000_0000));
		send_request(make_req(MODE_WRITE, W_MEN_BASE + 6'd2, 32'h0000_0008));
		send_request(make_req(MODE_READ, W_IRQP_BASE + 6'd2, $urandom));
		send_request(make_req(MODE_READ, W_FIQP_BASE, $urandom));
		send_request(make_req(MODE_READ, W_MBOX_CLR_BASE + 6'd11, $urandom));
		send_request(make_req(MODE_WRITE, W_MBOX_CLR_BASE + 6'd11, 32'hFFFF_FFFF));
		send_request(make_req(MODE_READ, W_IRQP_BASE + 6'd2, $urandom));
		send_request(make_req(MODE_READ, W_UNMAPPED_LO, $urandom));
		send_request(make_req(MODE_WRITE, W_UNMAPPED_HI, 32'hFFFF_FFFF));
		send_request(make_req(MODE_RESERVED, W_CONTROL, 32'h0000_0000));
		send_request(make_update(16'h0000, 1'b0, 4'h0));
		send_request(make_req(MODE_READ, W_CONTROL, $urandom));

		// random part
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				full_rate = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				r = make_update(16'($urandom & $urandom), 1'($urandom_range(0, 1)),
					4'($urandom_range(0, 15)));
			end else begin
				m = (sel < 65) ? MODE_WRITE : MODE_READ;
				case ($urandom_range(0, 7))
					0: w = 6'($urandom_range(0, 63));
					1: w = 6'($urandom_range(W_CONTROL, W_PMU_CLR));
					2: w = 6'(W_TEN_BASE + $urandom_range(0, 3));
					3: w = 6'(W_MEN_BASE + $urandom_range(0, 3));
					4: w = 6'(W_IRQP_BASE + $urandom_range(0, 7));
					default: w = 6'(W_MBOX_SET_BASE + $urandom_range(0, 31));
				endcase
				case ($urandom_range(0, 3))
					0: d = '1;
					1: d = 32'h1 << $urandom_range(0, 31);
					default: d = $urandom;
				endcase
				r = make_req(m, w, d);
			end
			send_request(r);
		end
		req_if.valid <= 1'b0;
		full_rate = 1'b0;

		while (sb.expected_rsp_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
